// File: rtl/core/qpi_pkg.sv
package qpi_pkg;

    localparam int DATA_WIDTH    = 32;
    localparam int GAIN_WIDTH    = DATA_WIDTH - 1;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADDR_WIDTH    = 5;
    localparam int REG_IDX_WIDTH = ADDR_WIDTH - 2;

    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // register indexes, byte address is 4 times the index
    localparam logic [REG_IDX_WIDTH-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_INT_GAIN    = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_SAMPLE_TIME = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_ACT_RES     = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_LEAK_IND    = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_VOLT_UPPER  = 3'd5;
    localparam logic [REG_IDX_WIDTH-1:0] REG_VOLT_LOWER  = 3'd6;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] cur_q_target;
        logic signed [DATA_WIDTH-1:0] cur_q_meas;
        logic signed [DATA_WIDTH-1:0] cur_d_meas;
        logic signed [DATA_WIDTH-1:0] elec_speed;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] volt_q_cmd;
        logic                         clamped;
    } t_out;

    typedef struct packed {
        logic        [GAIN_WIDTH-1:0] prop_gain;
        logic        [GAIN_WIDTH-1:0] int_gain;
        logic        [GAIN_WIDTH-1:0] sample_time;
        logic        [GAIN_WIDTH-1:0] active_resistance;
        logic        [GAIN_WIDTH-1:0] leakage_inductance;
        logic signed [DATA_WIDTH-1:0] volt_upper;
        logic signed [DATA_WIDTH-1:0] volt_lower;
    } t_cfg;

    // products formed by the shared multiplier, in issue order
    typedef enum logic [2:0] {
        MOP_P  = 3'd0,
        MOP_T  = 3'd1,
        MOP_WL = 3'd2,
        MOP_RA = 3'd3,
        MOP_KI = 3'd4,
        MOP_X  = 3'd5
    } t_mul_op;

    typedef struct packed {
        logic    cap;
        logic    mul_start;
        t_mul_op mul_op;
        logic    ld_sum;
        logic    ld_out;
    } t_dp_cmd;

endpackage

// File: rtl/core/q_axis_current_pi_controller_core.sv
// an accepted word is captured, then six products go in turn through one shared
// 32x32 multiplier, and the sum and the clamp are registered before o_out_valid rises;
// a new word is accepted only once the controller is back in idle
// a finished word may wait in the output register while the next is accepted
// reset (synchronous, i_rst_n low): controller idle, integrator and hold flag
// cleared, gains zero, voltage limits at the full signed range
module q_axis_current_pi_controller_core #(
    parameter int FRAC_BITS = qpi_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  qpi_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output qpi_pkg::t_out                  o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qpi_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int GW = qpi_pkg::GAIN_WIDTH;

    qpi_pkg::t_cfg    r_cfg;
    qpi_pkg::t_dp_cmd cmd;
    logic             mul_done;
    logic             wr_en;
    logic [qpi_pkg::REG_IDX_WIDTH-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[qpi_pkg::ADDR_WIDTH-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain          <= '0;
            r_cfg.int_gain           <= '0;
            r_cfg.sample_time        <= '0;
            r_cfg.active_resistance  <= '0;
            r_cfg.leakage_inductance <= '0;
            r_cfg.volt_upper         <= qpi_pkg::SAT_MAX;
            r_cfg.volt_lower         <= qpi_pkg::SAT_MIN;
        end else if (wr_en) begin
            unique case (reg_idx)
                qpi_pkg::REG_PROP_GAIN:   r_cfg.prop_gain          <= pwdata[GW-1:0];
                qpi_pkg::REG_INT_GAIN:    r_cfg.int_gain           <= pwdata[GW-1:0];
                qpi_pkg::REG_SAMPLE_TIME: r_cfg.sample_time        <= pwdata[GW-1:0];
                qpi_pkg::REG_ACT_RES:     r_cfg.active_resistance  <= pwdata[GW-1:0];
                qpi_pkg::REG_LEAK_IND:    r_cfg.leakage_inductance <= pwdata[GW-1:0];
                qpi_pkg::REG_VOLT_UPPER:  r_cfg.volt_upper         <= pwdata;
                qpi_pkg::REG_VOLT_LOWER:  r_cfg.volt_lower         <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            qpi_pkg::REG_PROP_GAIN:   prdata = {1'b0, r_cfg.prop_gain};
            qpi_pkg::REG_INT_GAIN:    prdata = {1'b0, r_cfg.int_gain};
            qpi_pkg::REG_SAMPLE_TIME: prdata = {1'b0, r_cfg.sample_time};
            qpi_pkg::REG_ACT_RES:     prdata = {1'b0, r_cfg.active_resistance};
            qpi_pkg::REG_LEAK_IND:    prdata = {1'b0, r_cfg.leakage_inductance};
            qpi_pkg::REG_VOLT_UPPER:  prdata = r_cfg.volt_upper;
            qpi_pkg::REG_VOLT_LOWER:  prdata = r_cfg.volt_lower;
            default:                  prdata = '0;
        endcase
    end

    qpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_mul_done (mul_done),
        .o_cmd      (cmd)
    );

    qpi_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in      (i_in_data),
        .i_cfg     (r_cfg),
        .o_mul_done(mul_done),
        .o_out     (o_out_data)
    );

endmodule

// File: rtl/core/qpi_mul.sv
module qpi_mul #(
    parameter int FRAC_BITS = qpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [qpi_pkg::DATA_WIDTH-1:0] i_a,
    input  logic signed [qpi_pkg::DATA_WIDTH-1:0] i_b,
    output logic                                  o_done,
    output logic signed [qpi_pkg::DATA_WIDTH-1:0] o_res
);

    localparam int W = qpi_pkg::DATA_WIDTH;

    logic                r_busy;
    logic                r_ph;
    logic                r_done;
    logic                r_neg;
    logic [W-1:0]        r_ma;
    logic [W-1:0]        r_mb;
    logic [2*W-1:0]      r_prod;
    logic signed [W-1:0] r_res;

    logic [W-1:0]        n_ma;
    logic [W-1:0]        n_mb;
    logic [2*W-1:0]      shifted;
    logic [2*W-1:0]      lim;
    logic [W-1:0]        mag;
    logic [W-1:0]        fin;

    // sign and magnitude form, most negative value fits as unsigned
    assign n_ma = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign n_mb = i_b[W-1] ? (~i_b + 1'b1) : i_b;

    // drop fraction bits, saturate magnitude, then restore the sign
    always_comb begin
        shifted = r_prod >> FRAC_BITS;
        lim     = {{W{1'b0}}, r_neg, {(W-1){~r_neg}}};
        mag     = (shifted > lim) ? lim[W-1:0] : shifted[W-1:0];
        fin     = r_neg ? (~mag + 1'b1) : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_ph   <= 1'b0;
            end else if (r_busy) begin
                if (r_ph) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_ph <= ~r_ph;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= n_ma;
            r_mb  <= n_mb;
            r_neg <= i_a[W-1] ^ i_b[W-1];
        end
        if (r_busy && !r_ph) begin
            r_prod <= r_ma * r_mb;
        end
        if (r_busy && r_ph) begin
            r_res <= fin;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: rtl/core/qpi_dp.sv
module qpi_dp #(
    parameter int FRAC_BITS = qpi_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qpi_pkg::t_dp_cmd i_cmd,
    input  qpi_pkg::t_in     i_in,
    input  qpi_pkg::t_cfg    i_cfg,
    output logic             o_mul_done,
    output qpi_pkg::t_out    o_out
);

    localparam int W = qpi_pkg::DATA_WIDTH;

    qpi_pkg::t_in     r_in;
    qpi_pkg::t_mul_op r_op;
    qpi_pkg::t_out    r_out;
    logic signed [W-1:0] r_p;
    logic signed [W-1:0] r_wl;
    logic signed [W-1:0] r_ra;
    logic signed [W-1:0] r_ki;
    logic signed [W-1:0] r_x;
    logic signed [W-1:0] r_sum;
    logic signed [W-1:0] r_integ;
    logic                r_hold;

    logic signed [W:0]   err_wide;
    logic signed [W-1:0] err;
    logic signed [W-1:0] mul_a;
    logic signed [W-1:0] mul_b;
    logic signed [W-1:0] mul_res;
    logic                mul_done;
    logic signed [W:0]   int_wide;
    logic signed [W-1:0] n_integ;
    logic signed [W+1:0] sum_wide;
    logic signed [W-1:0] n_sum;
    logic signed [W-1:0] vout;
    logic                clip;

    always_comb begin
        err_wide = {r_in.cur_q_target[W-1], r_in.cur_q_target}
                 - {r_in.cur_q_meas[W-1], r_in.cur_q_meas};
        if (err_wide[W] != err_wide[W-1]) begin
            err = err_wide[W] ? qpi_pkg::SAT_MIN : qpi_pkg::SAT_MAX;
        end else begin
            err = err_wide[W-1:0];
        end
    end

    // operand select for the product being issued
    always_comb begin
        unique case (i_cmd.mul_op)
            qpi_pkg::MOP_P: begin
                mul_a = {1'b0, i_cfg.prop_gain};
                mul_b = err;
            end
            qpi_pkg::MOP_T: begin
                mul_a = {1'b0, i_cfg.sample_time};
                mul_b = err;
            end
            qpi_pkg::MOP_WL: begin
                mul_a = {1'b0, i_cfg.leakage_inductance};
                mul_b = r_in.elec_speed;
            end
            qpi_pkg::MOP_RA: begin
                mul_a = {1'b0, i_cfg.active_resistance};
                mul_b = r_in.cur_q_meas;
            end
            qpi_pkg::MOP_KI: begin
                mul_a = {1'b0, i_cfg.int_gain};
                mul_b = r_integ;
            end
            qpi_pkg::MOP_X: begin
                mul_a = r_wl;
                mul_b = r_in.cur_d_meas;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    qpi_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mul_start),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    always_comb begin
        int_wide = {r_integ[W-1], r_integ} + {mul_res[W-1], mul_res};
        if (int_wide[W] != int_wide[W-1]) begin
            n_integ = int_wide[W] ? qpi_pkg::SAT_MIN : qpi_pkg::SAT_MAX;
        end else begin
            n_integ = int_wide[W-1:0];
        end
    end

    // exact four term sum, saturated once
    always_comb begin
        sum_wide = {{2{r_p[W-1]}}, r_p} + {{2{r_ki[W-1]}}, r_ki}
                 - {{2{r_ra[W-1]}}, r_ra} + {{2{r_x[W-1]}}, r_x};
        if (sum_wide[W+1:W-1] == 3'b000 || sum_wide[W+1:W-1] == 3'b111) begin
            n_sum = sum_wide[W-1:0];
        end else begin
            n_sum = sum_wide[W+1] ? qpi_pkg::SAT_MIN : qpi_pkg::SAT_MAX;
        end
    end

    // upper limit is tested first, also when the limits cross
    always_comb begin
        if (r_sum >= i_cfg.volt_upper) begin
            vout = i_cfg.volt_upper;
        end else if (r_sum <= i_cfg.volt_lower) begin
            vout = i_cfg.volt_lower;
        end else begin
            vout = r_sum;
        end
        clip = (vout != r_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_hold  <= 1'b0;
        end else begin
            // integrator frozen while the last word was clamped
            if (mul_done && r_op == qpi_pkg::MOP_T && !r_hold) begin
                r_integ <= n_integ;
            end
            if (i_cmd.ld_out) begin
                r_hold <= clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_in <= i_in;
        end
        if (i_cmd.mul_start) begin
            r_op <= i_cmd.mul_op;
        end
        if (mul_done) begin
            unique case (r_op)
                qpi_pkg::MOP_P:  r_p  <= mul_res;
                qpi_pkg::MOP_WL: r_wl <= mul_res;
                qpi_pkg::MOP_RA: r_ra <= mul_res;
                qpi_pkg::MOP_KI: r_ki <= mul_res;
                qpi_pkg::MOP_X:  r_x  <= mul_res;
                default: ;
            endcase
        end
        if (i_cmd.ld_sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.ld_out) begin
            r_out.volt_q_cmd <= vout;
            r_out.clamped    <= clip;
        end
    end

    assign o_mul_done = mul_done;
    assign o_out      = r_out;

endmodule

// File: rtl/core/qpi_ctrl.sv
module qpi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic             i_mul_done,
    output qpi_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_ISSUE = 10'b00_0000_0010,
        S_MP    = 10'b00_0000_0100,
        S_MT    = 10'b00_0000_1000,
        S_MWL   = 10'b00_0001_0000,
        S_MRA   = 10'b00_0010_0000,
        S_MKI   = 10'b00_0100_0000,
        S_MX    = 10'b00_1000_0000,
        S_SUM   = 10'b01_0000_0000,
        S_CLAMP = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_cmd.mul_op    = qpi_pkg::MOP_P;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = qpi_pkg::MOP_P;
                n_state         = S_MP;
            end
            // each finished product but the last issues the next one in the same cycle
            S_MP: begin
                if (i_mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = qpi_pkg::MOP_T;
                    n_state         = S_MT;
                end
            end
            S_MT: begin
                if (i_mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = qpi_pkg::MOP_WL;
                    n_state         = S_MWL;
                end
            end
            S_MWL: begin
                if (i_mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = qpi_pkg::MOP_RA;
                    n_state         = S_MRA;
                end
            end
            S_MRA: begin
                if (i_mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = qpi_pkg::MOP_KI;
                    n_state         = S_MKI;
                end
            end
            S_MKI: begin
                if (i_mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_op    = qpi_pkg::MOP_X;
                    n_state         = S_MX;
                end
            end
            S_MX: begin
                if (i_mul_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.ld_sum = 1'b1;
                n_state      = S_CLAMP;
            end
            S_CLAMP: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid & ~i_out_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int GW           = qpi_pkg::GAIN_WIDTH;
    localparam int AW           = qpi_pkg::ADDR_WIDTH;
    localparam int IW           = qpi_pkg::REG_IDX_WIDTH;
    localparam int FRAC         = qpi_pkg::FRAC_BITS_DEF;
    localparam int ONE          = 65536;
    localparam int ITEM_TARGET  = 1550;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_OFF     = 500;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    qpi_pkg::t_in          i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    qpi_pkg::t_out         o_out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [AW-1:0]         paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // shadow of the register file and controller state
    logic [GW-1:0]          kp_r, ki_r, ts_r, ra_r, ll_r;
    logic signed [31:0]     vup_r, vlo_r;
    logic signed [31:0]     integ_r;
    logic                   hold_r;

    qpi_pkg::t_out volt_cmd_q[$];
    int   err_count;
    int   cycle_count;
    int   word_count;
    int   hold_cycles;
    bit   no_idle;

    q_axis_current_pi_controller_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic longint sat_word(input longint v);
        if (v > longint'(qpi_pkg::SAT_MAX)) return longint'(qpi_pkg::SAT_MAX);
        if (v < longint'(qpi_pkg::SAT_MIN)) return longint'(qpi_pkg::SAT_MIN);
        return v;
    endfunction

    // exact product, magnitude truncated, then saturated
    function automatic longint fx_mul(input longint a, input longint b);
        longint prod, mag, lim;
        bit     neg;
        neg  = (a < 0) != (b < 0);
        prod = a * b;
        mag  = (prod < 0) ? -prod : prod;
        mag  = mag >> FRAC;
        lim  = neg ? 64'sd2147483648 : 64'sd2147483647;
        if (mag > lim) mag = lim;
        return neg ? -mag : mag;
    endfunction

    function automatic qpi_pkg::t_out pi_voltage_step(input qpi_pkg::t_in w);
        longint        err, iq, id, spd, wl, sum, vout;
        qpi_pkg::t_out r;
        err = sat_word(longint'($signed(w.cur_q_target)) - longint'($signed(w.cur_q_meas)));
        iq  = longint'($signed(w.cur_q_meas));
        id  = longint'($signed(w.cur_d_meas));
        spd = longint'($signed(w.elec_speed));
        if (!hold_r) begin
            integ_r = 32'(sat_word(longint'(integ_r) + fx_mul(longint'(ts_r), err)));
        end
        wl  = fx_mul(longint'(ll_r), spd);
        sum = sat_word(fx_mul(longint'(kp_r), err) + fx_mul(longint'(ki_r), longint'(integ_r))
                       - fx_mul(longint'(ra_r), iq) + fx_mul(wl, id));
        if (sum >= longint'(vup_r)) begin
            vout = longint'(vup_r);
        end else if (sum <= longint'(vlo_r)) begin
            vout = longint'(vlo_r);
        end else begin
            vout = sum;
        end
        hold_r       = (vout != sum);
        r.volt_q_cmd = 32'(vout);
        r.clamped    = hold_r;
        return r;
    endfunction

    function automatic qpi_pkg::t_in make_word(input logic [31:0] tq, input logic [31:0] mq,
                                               input logic [31:0] md, input logic [31:0] ws);
        qpi_pkg::t_in w;
        w.cur_q_target = tq;
        w.cur_q_meas   = mq;
        w.cur_d_meas   = md;
        w.elec_speed   = ws;
        return w;
    endfunction

    function automatic logic [31:0] rand_field();
        logic [31:0] v;
        case ($urandom_range(0, 15))
            0: v = qpi_pkg::SAT_MAX;
            1: v = qpi_pkg::SAT_MIN;
            2: v = '0;
            3, 4: v = $urandom;
            default: begin
                v = $urandom >> $urandom_range(8, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [GW-1:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return GW'($urandom >> $urandom_range(1, 31));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < 50) $display("mismatch at cycle %0d: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            qpi_pkg::REG_PROP_GAIN:   kp_r  = val[GW-1:0];
            qpi_pkg::REG_INT_GAIN:    ki_r  = val[GW-1:0];
            qpi_pkg::REG_SAMPLE_TIME: ts_r  = val[GW-1:0];
            qpi_pkg::REG_ACT_RES:     ra_r  = val[GW-1:0];
            qpi_pkg::REG_LEAK_IND:    ll_r  = val[GW-1:0];
            qpi_pkg::REG_VOLT_UPPER:  vup_r = val;
            qpi_pkg::REG_VOLT_LOWER:  vlo_r = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // the unused top bit of a gain word is set now and then, it must be ignored
    task automatic load_cfg(input logic [GW-1:0] kp, input logic [GW-1:0] ki,
                            input logic [GW-1:0] ts, input logic [GW-1:0] ra,
                            input logic [GW-1:0] ll, input logic [31:0] up,
                            input logic [31:0] lo);
        write_reg(qpi_pkg::REG_PROP_GAIN,   {1'($urandom_range(0, 7) == 0), kp});
        write_reg(qpi_pkg::REG_INT_GAIN,    {1'($urandom_range(0, 7) == 0), ki});
        write_reg(qpi_pkg::REG_SAMPLE_TIME, {1'($urandom_range(0, 7) == 0), ts});
        write_reg(qpi_pkg::REG_ACT_RES,     {1'($urandom_range(0, 7) == 0), ra});
        write_reg(qpi_pkg::REG_LEAK_IND,    {1'($urandom_range(0, 7) == 0), ll});
        write_reg(qpi_pkg::REG_VOLT_UPPER,  up);
        write_reg(qpi_pkg::REG_VOLT_LOWER,  lo);
    endtask

    task automatic send_word(input qpi_pkg::t_in w);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 9) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        volt_cmd_q.push_back(pi_voltage_step(w));
        word_count++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (volt_cmd_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, long hold-off on request, compare in order
    initial begin
        qpi_pkg::t_out want;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else if (!no_idle && $urandom_range(0, 99) < 9) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (volt_cmd_q.size() == 0) begin
                    report_mismatch("result word with nothing pending");
                end else begin
                    want = volt_cmd_q.pop_front();
                    if (o_out_data.volt_q_cmd !== want.volt_q_cmd)
                        report_mismatch($sformatf("volt_q_cmd got %0d want %0d",
                                                  $signed(o_out_data.volt_q_cmd),
                                                  $signed(want.volt_q_cmd)));
                    if (o_out_data.clamped !== want.clamped)
                        report_mismatch($sformatf("clamped got %b want %b",
                                                  o_out_data.clamped, want.clamped));
                end
            end
        end
    end

    // reset register values: gains zero, full output range
    task automatic test_reset_values();
        send_word(make_word(32'd0, 32'd0, 32'd0, 32'd0));
        send_word(make_word(qpi_pkg::SAT_MAX, qpi_pkg::SAT_MAX, qpi_pkg::SAT_MAX,
                            qpi_pkg::SAT_MAX));
        send_word(make_word(qpi_pkg::SAT_MIN, qpi_pkg::SAT_MIN, qpi_pkg::SAT_MIN,
                            qpi_pkg::SAT_MIN));
        drain();
    endtask

    // unit proportional gain only, so the sum equals the error
    task automatic test_clamp_edges();
        load_cfg(GW'(ONE), '0, '0, '0, '0, 5 * ONE, -5 * ONE);
        send_word(make_word(5 * ONE, 0, 0, 0));
        send_word(make_word(0, 5 * ONE, 0, 0));
        send_word(make_word(6 * ONE, 0, ONE, ONE));
        send_word(make_word(2 * ONE, 0, 0, 0));
        send_word(make_word(-7 * ONE, 0, 0, 0));
        send_word(make_word(qpi_pkg::SAT_MAX, qpi_pkg::SAT_MIN, 0, 0));
        drain();
    endtask

    // largest gains, with full scale and zero inputs
    task automatic test_product_saturation();
        load_cfg('1, '1, '1, '1, '1, qpi_pkg::SAT_MAX, qpi_pkg::SAT_MIN);
        send_word(make_word(qpi_pkg::SAT_MAX, qpi_pkg::SAT_MAX, qpi_pkg::SAT_MAX,
                            qpi_pkg::SAT_MAX));
        send_word(make_word(qpi_pkg::SAT_MIN, qpi_pkg::SAT_MIN, qpi_pkg::SAT_MIN,
                            qpi_pkg::SAT_MIN));
        send_word(make_word(qpi_pkg::SAT_MIN, qpi_pkg::SAT_MAX, qpi_pkg::SAT_MAX,
                            qpi_pkg::SAT_MIN));
        send_word(make_word(0, 0, 0, 0));
        drain();
    endtask

    // integrator runs into the upper limit, freezes, then unwinds
    task automatic test_anti_windup();
        load_cfg('0, GW'(ONE), GW'(ONE), GW'(ONE / 2), GW'(ONE / 4), 3 * ONE, -3 * ONE);
        repeat (4) send_word(make_word(ONE, 0, 2 * ONE, ONE));
        send_word(make_word(-ONE, 4 * ONE, 2 * ONE, ONE));
        repeat (2) send_word(make_word(-ONE, 0, 2 * ONE, ONE));
        drain();
    endtask

    // upper limit below lower limit
    task automatic test_crossed_limits();
        load_cfg(GW'(ONE), '0, '0, '0, '0, -ONE, ONE);
        send_word(make_word(0, 0, 0, 0));
        send_word(make_word(-2 * ONE, 0, 0, 0));
        send_word(make_word(3 * ONE, 0, 0, 0));
        drain();
    endtask

    // output held off long enough that the input side backs up
    task automatic test_output_backpressure();
        load_cfg(GW'(ONE), GW'(ONE / 8), GW'(ONE / 16), GW'(ONE / 4), GW'(ONE / 2),
                 40 * ONE, -40 * ONE);
        hold_cycles = HOLD_OFF;
        repeat (24) send_word(make_word(rand_field(), rand_field(), rand_field(), rand_field()));
        drain();
    endtask

    task automatic test_random_traffic();
        int          phase;
        int          n;
        logic [31:0] up, lo, mag;
        phase = 0;
        while (word_count < ITEM_TARGET) begin
            case ($urandom_range(0, 7))
                0: begin
                    up = qpi_pkg::SAT_MAX;
                    lo = qpi_pkg::SAT_MIN;
                end
                1: begin
                    up = -($urandom >> $urandom_range(4, 24));
                    lo = $urandom >> $urandom_range(4, 24);
                end
                2: begin
                    up = $urandom;
                    lo = up;
                end
                default: begin
                    mag = $urandom >> $urandom_range(4, 24);
                    up  = mag;
                    lo  = -($urandom >> $urandom_range(4, 24));
                end
            endcase
            load_cfg(rand_gain(), rand_gain(), rand_gain(), rand_gain(), rand_gain(), up, lo);
            n       = (phase == 3) ? 200 : $urandom_range(20, 90);
            no_idle = (phase == 3);
            repeat (n) send_word(make_word(rand_field(), rand_field(), rand_field(),
                                           rand_field()));
            drain();
            no_idle = 1'b0;
            phase++;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        kp_r        = '0;
        ki_r        = '0;
        ts_r        = '0;
        ra_r        = '0;
        ll_r        = '0;
        vup_r       = qpi_pkg::SAT_MAX;
        vlo_r       = qpi_pkg::SAT_MIN;
        integ_r     = '0;
        hold_r      = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        word_count  = 0;
        hold_cycles = 0;
        no_idle     = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_clamp_edges();
        test_product_saturation();
        test_anti_windup();
        test_crossed_limits();
        test_output_backpressure();
        test_random_traffic();

        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
